FILE: rtl/core/aspect_fit_display_rect_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the aspect fit display rectangle block
// Shared property forms used by the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef ASPECT_FIT_DISPLAY_RECT_DEFINES_SVH
`define ASPECT_FIT_DISPLAY_RECT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AFDR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define AFDR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/afdr_pkg.sv
// ----------------------------------------------------------------------------
// Aspect fit display rectangle package
// Constants shared by the stages of the aspect fit pipeline.
// ----------------------------------------------------------------------------
package afdr_pkg;

  localparam int COORD_BITS_DEF = 14;
  localparam int SAR_BITS       = 16;

endpackage

FILE: rtl/core/afdr_mul.sv
// ----------------------------------------------------------------------------
// Aspect fit multiply stages
// Two register stages that form the aspect products and the rounded dividends.
// ----------------------------------------------------------------------------
module afdr_mul #(
  parameter int CB = afdr_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic [1:0]                          en,
  input  logic [CB-1:0]                       picture_width,
  input  logic [CB-1:0]                       picture_height,
  input  logic [afdr_pkg::SAR_BITS-1:0]       sar_num,
  input  logic [afdr_pkg::SAR_BITS-1:0]       sar_den,
  input  logic [CB-1:0]                       win_width,
  input  logic [CB-1:0]                       win_height,
  output logic [2*CB+afdr_pkg::SAR_BITS-1:0]  dvd_a,
  output logic [CB+afdr_pkg::SAR_BITS-1:0]    dvs_a,
  output logic [2*CB+afdr_pkg::SAR_BITS-1:0]  dvd_b,
  output logic [CB+afdr_pkg::SAR_BITS-1:0]    dvs_b
);
  import afdr_pkg::*;

  localparam int PW = CB + SAR_BITS;
  localparam int DW = 2 * CB + SAR_BITS;

  logic                sar_unk;
  logic [SAR_BITS-1:0] sn_e;
  logic [SAR_BITS-1:0] sd_e;
  logic [CB-1:0]       pw_e;
  logic [CB-1:0]       ph_e;
  logic [PW-1:0]       num_nxt;
  logic [PW-1:0]       den_nxt;
  logic [PW-1:0]       num_r;
  logic [PW-1:0]       den_r;
  logic [DW-1:0]       dvd_a_nxt;
  logic [DW-1:0]       dvd_b_nxt;
  logic [DW-1:0]       dvd_a_r;
  logic [DW-1:0]       dvd_b_r;
  logic [PW-1:0]       dvs_a_r;
  logic [PW-1:0]       dvs_b_r;

  // An unknown sample aspect counts as square pixels.
  always_comb begin
    sar_unk   = (sar_num == '0) || (sar_den == '0);
    sn_e      = sar_unk ? SAR_BITS'(1) : sar_num;
    sd_e      = sar_unk ? SAR_BITS'(1) : sar_den;
    pw_e      = (picture_width == '0) ? CB'(1) : picture_width;
    ph_e      = (picture_height == '0) ? CB'(1) : picture_height;
    num_nxt   = PW'(sn_e) * PW'(pw_e);
    den_nxt   = PW'(sd_e) * PW'(ph_e);
    dvd_a_nxt = DW'(win_height) * DW'(num_r) + DW'(den_r >> 1);
    dvd_b_nxt = DW'(win_width) * DW'(den_r) + DW'(num_r >> 1);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      num_r <= num_nxt;
      den_r <= den_nxt;
    end
    if (en[1]) begin
      dvd_a_r <= dvd_a_nxt;
      dvs_a_r <= den_r;
      dvd_b_r <= dvd_b_nxt;
      dvs_b_r <= num_r;
    end
  end

  assign dvd_a = dvd_a_r;
  assign dvs_a = dvs_a_r;
  assign dvd_b = dvd_b_r;
  assign dvs_b = dvs_b_r;

endmodule

FILE: rtl/core/afdr_div.sv
// ----------------------------------------------------------------------------
// Aspect fit pipelined divider
// Restoring divider with one quotient bit per stage and a saturation flag.
// ----------------------------------------------------------------------------
module afdr_div #(
  parameter int CB = afdr_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic [CB+1:0]                       en,
  input  logic [2*CB+afdr_pkg::SAR_BITS-1:0]  dvd,
  input  logic [CB+afdr_pkg::SAR_BITS-1:0]    dvs,
  output logic [CB:0]                         quot,
  output logic                                ovf
);
  import afdr_pkg::*;

  localparam int PW = CB + SAR_BITS;
  localparam int DW = 2 * CB + SAR_BITS;
  localparam int CW = DW + 2;
  localparam int QW = CB + 1;
  localparam int NS = CB + 2;

  logic [DW-1:0] rem_r [0:NS-2];
  logic [PW-1:0] dvs_r [0:NS-2];
  logic [QW-1:0] q_r   [0:NS-1];
  logic          ovf_r [0:NS-1];
  logic          ovf_nxt;

  // The first stage flags quotients that do not fit in the result width.
  assign ovf_nxt = CW'(dvd) >= (CW'(dvs) << QW);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      rem_r[0] <= dvd;
      dvs_r[0] <= dvs;
      q_r[0]   <= '0;
      ovf_r[0] <= ovf_nxt;
    end
  end

  for (genvar s = 1; s < NS; s++) begin : g_stage
    localparam int B = NS - 1 - s;
    logic [CW-1:0] shd;
    logic          ge;
    logic [QW-1:0] q_nxt;

    always_comb begin
      shd   = CW'(dvs_r[s-1]) << B;
      ge    = CW'(rem_r[s-1]) >= shd;
      q_nxt = q_r[s-1] | (ge ? (QW'(1) << B) : QW'(0));
    end

    always_ff @(posedge clk) begin
      if (en[s]) begin
        q_r[s]   <= q_nxt;
        ovf_r[s] <= ovf_r[s-1];
      end
    end

    if (s < NS - 1) begin : g_keep
      logic [DW-1:0] rem_nxt;

      assign rem_nxt = ge ? DW'(CW'(rem_r[s-1]) - shd) : rem_r[s-1];

      always_ff @(posedge clk) begin
        if (en[s]) begin
          rem_r[s] <= rem_nxt;
          dvs_r[s] <= dvs_r[s-1];
        end
      end
    end
  end

  assign quot = q_r[NS-1];
  assign ovf  = ovf_r[NS-1];

endmodule

FILE: rtl/core/afdr_place.sv
// ----------------------------------------------------------------------------
// Aspect fit placement stages
// Chooses the fit direction, then centers and clamps the rectangle.
// ----------------------------------------------------------------------------
module afdr_place #(
  parameter int CB = afdr_pkg::COORD_BITS_DEF
) (
  input  logic          clk,
  input  logic [1:0]    en,
  input  logic [CB:0]   quot_a,
  input  logic          ovf_a,
  input  logic [CB:0]   quot_b,
  input  logic          ovf_b,
  input  logic [CB-1:0] win_left,
  input  logic [CB-1:0] win_top,
  input  logic [CB-1:0] win_width,
  input  logic [CB-1:0] win_height,
  output logic [CB:0]   rect_x,
  output logic [CB:0]   rect_y,
  output logic [CB-1:0] rect_w,
  output logic [CB-1:0] rect_h
);
  import afdr_pkg::*;

  logic [CB:0]   wa_even;
  logic          fit_h;
  logic [CB-1:0] w_nxt;
  logic [CB-1:0] h_nxt;
  logic [CB-1:0] w_r;
  logic [CB-1:0] h_r;
  logic [CB-1:0] left_r;
  logic [CB-1:0] top_r;
  logic [CB-1:0] ww_r;
  logic [CB-1:0] wh_r;
  logic [CB-1:0] x_off;
  logic [CB-1:0] y_off;
  logic [CB:0]   rect_x_nxt;
  logic [CB:0]   rect_y_nxt;
  logic [CB-1:0] rect_w_nxt;
  logic [CB-1:0] rect_h_nxt;
  logic [CB:0]   rect_x_r;
  logic [CB:0]   rect_y_r;
  logic [CB-1:0] rect_w_r;
  logic [CB-1:0] rect_h_r;

  // Full window height is kept when the even width from it fits the window.
  always_comb begin
    wa_even = {quot_a[CB:1], 1'b0};
    fit_h   = !ovf_a && (wa_even <= (CB+1)'(win_width));
    if (fit_h) begin
      w_nxt = CB'(wa_even);
      h_nxt = win_height;
    end else begin
      w_nxt = win_width;
      h_nxt = ovf_b ? '1 : CB'({quot_b[CB:1], 1'b0});
    end
  end

  always_comb begin
    x_off      = (w_r <= ww_r) ? ((ww_r - w_r) >> 1) : '0;
    y_off      = (h_r <= wh_r) ? ((wh_r - h_r) >> 1) : '0;
    rect_x_nxt = (CB+1)'(left_r) + (CB+1)'(x_off);
    rect_y_nxt = (CB+1)'(top_r) + (CB+1)'(y_off);
    rect_w_nxt = (w_r == '0) ? CB'(1) : w_r;
    rect_h_nxt = (h_r == '0) ? CB'(1) : h_r;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      w_r    <= w_nxt;
      h_r    <= h_nxt;
      left_r <= win_left;
      top_r  <= win_top;
      ww_r   <= win_width;
      wh_r   <= win_height;
    end
    if (en[1]) begin
      rect_x_r <= rect_x_nxt;
      rect_y_r <= rect_y_nxt;
      rect_w_r <= rect_w_nxt;
      rect_h_r <= rect_h_nxt;
    end
  end

  assign rect_x = rect_x_r;
  assign rect_y = rect_y_r;
  assign rect_w = rect_w_r;
  assign rect_h = rect_h_r;

endmodule

FILE: rtl/core/aspect_fit_display_rect.sv
// ----------------------------------------------------------------------------
// Aspect fit display rectangle
// Letterbox and pillarbox fit of a picture into a screen window.
// ----------------------------------------------------------------------------
// The block accepts one transaction per cycle while in_tready is high and
// returns one result per transaction, in order. Two multiply stages in front
// feed the two restoring dividers that run side by side, each resolving one
// quotient bit per pipeline stage, and two placement stages follow behind.
// Every stage holds its own valid bit, so a stall at the output only stops the
// stages that are full and input transactions keep filling empty stages while
// a result waits.
module aspect_fit_display_rect #(
  parameter int COORD_BITS = afdr_pkg::COORD_BITS_DEF,
  localparam int IN_W  = ((6 * COORD_BITS + 2 * afdr_pkg::SAR_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((4 * COORD_BITS + 2 + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // win_left, win_top, win_width, win_height, picture_width, picture_height,
  // sar_num, sar_den
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // rect_x, rect_y, rect_w, rect_h
  output logic [OUT_W-1:0] out_tdata
);
  import afdr_pkg::*;

  localparam int CB   = COORD_BITS;
  localparam int PW   = CB + SAR_BITS;
  localparam int DW   = 2 * CB + SAR_BITS;
  localparam int NS   = CB + 2;
  localparam int DEND = NS + 1;
  localparam int NST  = NS + 4;
  localparam int SW   = 4 * CB;

  logic [CB-1:0]       win_left;
  logic [CB-1:0]       win_top;
  logic [CB-1:0]       win_width;
  logic [CB-1:0]       win_height;
  logic [CB-1:0]       picture_width;
  logic [CB-1:0]       picture_height;
  logic [SAR_BITS-1:0] sar_num;
  logic [SAR_BITS-1:0] sar_den;

  logic [NST:0]        en;
  logic                vld_r  [0:NST-1];
  logic [SW-1:0]       side_r [0:DEND];

  logic [DW-1:0]       dvd_a;
  logic [DW-1:0]       dvd_b;
  logic [PW-1:0]       dvs_a;
  logic [PW-1:0]       dvs_b;
  logic [CB:0]         quot_a;
  logic [CB:0]         quot_b;
  logic                ovf_a;
  logic                ovf_b;
  logic [CB:0]         rect_x;
  logic [CB:0]         rect_y;
  logic [CB-1:0]       rect_w;
  logic [CB-1:0]       rect_h;

  assign win_left       = in_tdata[0*CB +: CB];
  assign win_top        = in_tdata[1*CB +: CB];
  assign win_width      = in_tdata[2*CB +: CB];
  assign win_height     = in_tdata[3*CB +: CB];
  assign picture_width  = in_tdata[4*CB +: CB];
  assign picture_height = in_tdata[5*CB +: CB];
  assign sar_num        = in_tdata[6*CB +: SAR_BITS];
  assign sar_den        = in_tdata[6*CB+SAR_BITS +: SAR_BITS];

  // A stage may load when it is empty or when the stage after it moves on.
  always_comb begin
    en[NST] = out_tready;
    for (int k = NST - 1; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NST; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else begin
      if (en[0]) begin
        vld_r[0] <= in_tvalid;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      side_r[0] <= {win_height, win_width, win_top, win_left};
    end
    for (int k = 1; k <= DEND; k++) begin
      if (en[k]) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  afdr_mul #(
    .CB (CB)
  ) u_mul (
    .clk            (clk),
    .en             (en[1:0]),
    .picture_width  (picture_width),
    .picture_height (picture_height),
    .sar_num        (sar_num),
    .sar_den        (sar_den),
    .win_width      (side_r[0][2*CB +: CB]),
    .win_height     (side_r[0][3*CB +: CB]),
    .dvd_a          (dvd_a),
    .dvs_a          (dvs_a),
    .dvd_b          (dvd_b),
    .dvs_b          (dvs_b)
  );

  afdr_div #(
    .CB (CB)
  ) u_div_w (
    .clk  (clk),
    .en   (en[2 +: NS]),
    .dvd  (dvd_a),
    .dvs  (dvs_a),
    .quot (quot_a),
    .ovf  (ovf_a)
  );

  afdr_div #(
    .CB (CB)
  ) u_div_h (
    .clk  (clk),
    .en   (en[2 +: NS]),
    .dvd  (dvd_b),
    .dvs  (dvs_b),
    .quot (quot_b),
    .ovf  (ovf_b)
  );

  afdr_place #(
    .CB (CB)
  ) u_place (
    .clk        (clk),
    .en         (en[DEND+1 +: 2]),
    .quot_a     (quot_a),
    .ovf_a      (ovf_a),
    .quot_b     (quot_b),
    .ovf_b      (ovf_b),
    .win_left   (side_r[DEND][0*CB +: CB]),
    .win_top    (side_r[DEND][1*CB +: CB]),
    .win_width  (side_r[DEND][2*CB +: CB]),
    .win_height (side_r[DEND][3*CB +: CB]),
    .rect_x     (rect_x),
    .rect_y     (rect_y),
    .rect_w     (rect_w),
    .rect_h     (rect_h)
  );

  assign in_tready  = en[0];
  assign out_tvalid = vld_r[NST-1];
  assign out_tdata  = OUT_W'({rect_h, rect_w, rect_y, rect_x});

`include "aspect_fit_display_rect_defines.svh"

  `AFDR_ASSERT_IMP(a_rect_nonzero, clk, rst_n, out_tvalid, (rect_w != '0) && (rect_h != '0), "Result rectangle has a zero side.")
  `AFDR_ASSERT_IMP(a_empty_end_ready, clk, rst_n, !out_tvalid, in_tready, "Input stalled while the output stage is empty.")
  `AFDR_ASSERT_NXT(a_accept_loads, clk, rst_n, in_tvalid && in_tready, vld_r[0], "Accepted transaction did not enter the first stage.")

endmodule

FILE: verif/aspect_fit_display_rect_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Aspect fit display rectangle testbench
// Streams window and picture descriptions into the block, including the
// unknown aspect, zero picture size and empty window cases and a large
// random mix. It predicts every letterbox or pillarbox rectangle and compares
// the results in order, while both sides idle and stall at random.
// ----------------------------------------------------------------------------
module aspect_fit_display_rect_tb;

  localparam int COORD_BITS = afdr_pkg::COORD_BITS_DEF;
  localparam int SAR_BITS   = afdr_pkg::SAR_BITS;
  localparam int IN_W  = ((6 * COORD_BITS + 2 * SAR_BITS + 7) / 8) * 8;
  localparam int OUT_W = ((4 * COORD_BITS + 2 + 7) / 8) * 8;
  localparam int COORD_MAX = (1 << COORD_BITS) - 1;
  localparam int SAR_MAX   = (1 << SAR_BITS) - 1;
  localparam longint unsigned EVEN_MASK = ~64'd1;
  localparam int RANDOM_ITEMS   = 1300;
  localparam int LONG_HOLD      = 300;
  localparam int DRAIN_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic [COORD_BITS-1:0] win_left;
    logic [COORD_BITS-1:0] win_top;
    logic [COORD_BITS-1:0] win_width;
    logic [COORD_BITS-1:0] win_height;
    logic [COORD_BITS-1:0] img_width;
    logic [COORD_BITS-1:0] img_height;
    logic [SAR_BITS-1:0]   sar_num;
    logic [SAR_BITS-1:0]   sar_den;
  } fit_req_t;

  typedef struct packed {
    logic [COORD_BITS:0]   rect_x;
    logic [COORD_BITS:0]   rect_y;
    logic [COORD_BITS-1:0] rect_w;
    logic [COORD_BITS-1:0] rect_h;
  } disp_rect_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  fit_req_t   pending_reqs[$];
  disp_rect_t expected_rects[$];
  fit_req_t   offered;
  disp_rect_t got_rect;
  disp_rect_t want_rect;
  int         n_queued = 0;
  int         n_sent = 0;
  int         n_checked = 0;
  int         n_unknown_sar = 0;
  int         n_errors = 0;
  int         send_gap = 0;
  int         recv_hold = 0;
  int         idle_cycles = 0;
  int         rg;
  bit         long_hold_req = 1'b0;
  bit         long_hold_done = 1'b0;

  aspect_fit_display_rect dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic disp_rect_t fit_rect(fit_req_t r);
    longint unsigned sn, sd, pw, ph, ww, wh, num, den, w, h, x, y;
    disp_rect_t res;
    sn = 64'(r.sar_num);
    sd = 64'(r.sar_den);
    pw = 64'(r.img_width);
    ph = 64'(r.img_height);
    ww = 64'(r.win_width);
    wh = 64'(r.win_height);
    if (sn == 0 || sd == 0) begin
      sn = 1;
      sd = 1;
    end
    if (pw == 0) pw = 1;
    if (ph == 0) ph = 1;
    num = sn * pw;
    den = sd * ph;
    h = wh;
    w = ((h * num + den / 2) / den) & EVEN_MASK;
    if (w > ww) begin
      w = ww;
      h = ((w * den + num / 2) / num) & EVEN_MASK;
    end
    x = (w <= ww) ? (ww - w) / 2 : 0;
    y = (h <= wh) ? (wh - h) / 2 : 0;
    if (w < 1) w = 1;
    if (h < 1) h = 1;
    res.rect_x = (COORD_BITS + 1)'(64'(r.win_left) + x);
    res.rect_y = (COORD_BITS + 1)'(64'(r.win_top) + y);
    res.rect_w = COORD_BITS'(w);
    res.rect_h = COORD_BITS'(h);
    return res;
  endfunction

  function automatic int rand_gap();
    int r;
    r = int'($urandom_range(0, 99));
    if (r < 55) return 0;
    if (r < 90) return int'($urandom_range(1, 3));
    return int'($urandom_range(6, 40));
  endfunction

  function automatic logic [COORD_BITS-1:0] corner_coord();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return COORD_BITS'(1);
      2: return COORD_BITS'(2);
      3: return COORD_BITS'(COORD_MAX - 1);
      4: return COORD_BITS'(COORD_MAX);
      default: return COORD_BITS'($urandom_range(0, COORD_MAX));
    endcase
  endfunction

  function automatic fit_req_t make_req(int left, int top, int ww, int wh, int pw, int ph,
                                        int sn, int sd);
    fit_req_t r;
    r.win_left   = COORD_BITS'(left);
    r.win_top    = COORD_BITS'(top);
    r.win_width  = COORD_BITS'(ww);
    r.win_height = COORD_BITS'(wh);
    r.img_width  = COORD_BITS'(pw);
    r.img_height = COORD_BITS'(ph);
    r.sar_num    = SAR_BITS'(sn);
    r.sar_den    = SAR_BITS'(sd);
    return r;
  endfunction

  function automatic fit_req_t rand_req();
    fit_req_t r;
    int kind;
    kind = int'($urandom_range(0, 99));
    if (kind < 40) begin
      r = make_req($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                   $urandom_range(0, 4095), $urandom_range(0, 4095),
                   $urandom_range(1, 4096), $urandom_range(1, 4096),
                   $urandom_range(1, 64), $urandom_range(1, 64));
    end else if (kind < 75) begin
      r = make_req($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                   $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                   $urandom_range(1, COORD_MAX), $urandom_range(1, COORD_MAX),
                   $urandom_range(0, SAR_MAX), $urandom_range(0, SAR_MAX));
    end else if (kind < 90) begin
      r = make_req($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                   $urandom_range(0, 4095), $urandom_range(0, 4095),
                   $urandom_range(1, 4096), $urandom_range(1, 4096),
                   $urandom_range(0, 1) ? 0 : $urandom_range(0, SAR_MAX),
                   $urandom_range(0, 1) ? 0 : $urandom_range(0, SAR_MAX));
    end else begin
      r = make_req(corner_coord(), corner_coord(), corner_coord(), corner_coord(),
                   corner_coord(), corner_coord(),
                   $urandom_range(0, 1) ? SAR_MAX : $urandom_range(0, 2),
                   $urandom_range(0, 1) ? SAR_MAX : $urandom_range(0, 2));
    end
    return r;
  endfunction

  task automatic queue_req(fit_req_t r);
    pending_reqs.push_back(r);
    n_queued++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      send_gap  <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_rects.push_back(fit_rect(offered));
        if (offered.sar_num == 0 || offered.sar_den == 0) n_unknown_sar++;
        n_sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap  <= send_gap - 1;
          in_tvalid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          offered = pending_reqs.pop_front();
          in_tdata <= {{(IN_W - 6 * COORD_BITS - 2 * SAR_BITS){1'b0}},
                       offered.sar_den, offered.sar_num,
                       offered.img_height, offered.img_width,
                       offered.win_height, offered.win_width,
                       offered.win_top, offered.win_left};
          in_tvalid <= 1'b1;
          send_gap  <= (n_sent % 128 < 24) ? 0 : rand_gap();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      recv_hold  <= 0;
    end else if (recv_hold > 0) begin
      out_tready <= 1'b0;
      recv_hold  <= recv_hold - 1;
    end else if (long_hold_req && !long_hold_done) begin
      out_tready     <= 1'b0;
      recv_hold      <= LONG_HOLD;
      long_hold_done <= 1'b1;
    end else begin
      rg = (n_checked % 128 < 24) ? 0 : rand_gap();
      if (rg == 0) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b0;
        recv_hold  <= rg - 1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_rect.rect_x = out_tdata[COORD_BITS:0];
      got_rect.rect_y = out_tdata[2*COORD_BITS+1:COORD_BITS+1];
      got_rect.rect_w = out_tdata[3*COORD_BITS+1:2*COORD_BITS+2];
      got_rect.rect_h = out_tdata[4*COORD_BITS+1:3*COORD_BITS+2];
      if (expected_rects.size() == 0) begin
        $error("Result transaction with no pending expectation: %h", out_tdata);
        n_errors++;
      end else begin
        want_rect = expected_rects.pop_front();
        if (got_rect.rect_x !== want_rect.rect_x) begin
          $error("rect_x: expected %0d, actual %0d", want_rect.rect_x, got_rect.rect_x);
          n_errors++;
        end
        if (got_rect.rect_y !== want_rect.rect_y) begin
          $error("rect_y: expected %0d, actual %0d", want_rect.rect_y, got_rect.rect_y);
          n_errors++;
        end
        if (got_rect.rect_w !== want_rect.rect_w) begin
          $error("rect_w: expected %0d, actual %0d", want_rect.rect_w, got_rect.rect_w);
          n_errors++;
        end
        if (got_rect.rect_h !== want_rect.rect_h) begin
          $error("rect_h: expected %0d, actual %0d", want_rect.rect_h, got_rect.rect_h);
          n_errors++;
        end
      end
      n_checked++;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Timed out after %0d cycles without a transaction.", idle_cycles);
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    // Unknown aspect, zero picture size and empty windows first.
    queue_req(make_req(0, 0, 0, 0, 0, 0, 0, 0));
    queue_req(make_req(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                       SAR_MAX, SAR_MAX));
    queue_req(make_req(10, 20, 1920, 1080, 720, 576, 0, 5));
    queue_req(make_req(10, 20, 1920, 1080, 720, 576, 7, 0));
    queue_req(make_req(5, 5, 800, 600, 0, 480, 1, 1));
    queue_req(make_req(5, 5, 800, 600, 640, 0, 1, 1));
    queue_req(make_req(100, 100, 0, 600, 640, 480, 1, 1));
    queue_req(make_req(100, 100, 800, 0, 640, 480, 1, 1));
    queue_req(make_req(0, 0, 1920, 1080, 1280, 720, 1, 1));
    queue_req(make_req(0, 0, 1920, 1080, 640, 480, 1, 1));
    queue_req(make_req(0, 0, 1280, 1080, 1920, 1080, 1, 1));
    queue_req(make_req(3, 3, 1000, 1000, COORD_MAX, 1, SAR_MAX, 1));
    queue_req(make_req(3, 3, 1000, 1000, 1, COORD_MAX, 1, SAR_MAX));
    queue_req(make_req(0, 0, 16, 1, 2, 1, 1, 2));
    queue_req(make_req(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 1, 1, 1, 1));
    queue_req(make_req(7, 9, 4000, 1081, 1920, 1080, 1, 1));
    queue_req(make_req(1, 1, 1, 1, 1, 1, 1, 1));
    queue_req(make_req(0, 0, 1024, 768, 720, 576, 64, 45));
    queue_req(make_req(0, 0, 1024, 768, 720, 480, 32, 27));
    queue_req(make_req(0, 0, 3, 5, 3, 5, 1, 1));
    queue_req(make_req(0, 0, COORD_MAX, 2, 1, COORD_MAX, SAR_MAX, 1));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Sender pause: everything must come back before the random part starts.
    while (n_sent != n_queued || expected_rects.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    for (int i = 0; i < RANDOM_ITEMS; i++) queue_req(rand_req());
    long_hold_req = 1'b1;

    while (n_sent != n_queued || expected_rects.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d display rectangles from %0d input transactions,", n_checked,
             n_sent);
    $display("%0d of them with an unknown sample aspect, under random stalls.",
             n_unknown_sar);
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
